/* rtl/line_rast_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rast_pkg
// shared widths, request codes and direction codes of the line rasterizer
// ----------------------------------------------------------------------------
package line_rast_pkg;

    localparam int COORD_W = 8;
    localparam int ROW_W   = 7;
    localparam int ADDR_W  = 15;
    localparam int COLOR_W = 16;
    localparam int ERR_W   = 9;
    localparam int COUNT_W = 9;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ERR_W-1:0]   err_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [COLOR_W-1:0] color_t;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // direction of travel along one axis
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd3
    } dir_t;

endpackage

/* rtl/line_rast_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rast_if
// valid/ready channels of the line rasterizer: request in, pixel write out
// ----------------------------------------------------------------------------
interface line_rast_req_if;

    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [line_rast_pkg::COORD_W-1:0]   x_start;
    logic [line_rast_pkg::COORD_W-1:0]   y_start;
    logic [line_rast_pkg::COORD_W-1:0]   x_end;
    logic [line_rast_pkg::COORD_W-1:0]   y_end;
    logic [line_rast_pkg::COLOR_W-1:0]   color;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end, color,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end, color,
        output ready
    );

endinterface

interface line_rast_pix_if;

    logic                                valid;
    logic                                ready;
    logic [line_rast_pkg::COORD_W-1:0]   pixel_x;
    logic [line_rast_pkg::ROW_W-1:0]     pixel_y;
    logic [line_rast_pkg::ADDR_W-1:0]    pixel_addr;
    logic [line_rast_pkg::COLOR_W-1:0]   pixel_word;
    logic                                last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_addr, pixel_word, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_addr, pixel_word, last,
        output ready
    );

endinterface

/* rtl/line_rasterizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// incremental line drawing into a row-major RGB565 framebuffer
// ----------------------------------------------------------------------------
// A start transaction latches two endpoints and a color and yields no pixel;
// every following step transaction yields one framebuffer write (column, row,
// word address and byte-swapped color) until the line's max(dx,dy)+1 pixels
// are out, the final one flagged by last. Steps with no line in progress are
// absorbed silently, and a start replaces any line in progress. The block
// takes one transaction per clock while the output register is empty or being
// drained in the same cycle. The line state registers and one output register
// are separated only by the error add/compare/subtract of each axis and the
// row-times-width multiply, so a pixel enters the output register in the cycle
// after its step is accepted. Columns saturate at SCREEN_WIDTH-1 and rows at
// SCREEN_HEIGHT-1; the address wraps to 15 bits.
// ----------------------------------------------------------------------------
module line_rasterizer_unit #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    line_rast_req_if.sink          req,
    line_rast_pix_if.source        pix
);

    localparam int PROD_W = line_rast_pkg::COORD_W + line_rast_pkg::COUNT_W;

    localparam line_rast_pkg::coord_t COL_MAX =
        line_rast_pkg::COORD_W'(SCREEN_WIDTH - 1);
    localparam line_rast_pkg::coord_t ROW_MAX =
        line_rast_pkg::COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic [PROD_W-1:0] ROW_PITCH = PROD_W'(SCREEN_WIDTH);

    // line state
    logic                        active_reg,    active_next;
    line_rast_pkg::coord_t       cur_col_reg,   cur_col_next;
    line_rast_pkg::coord_t       cur_row_reg,   cur_row_next;
    line_rast_pkg::err_t         col_err_reg,   col_err_next;
    line_rast_pkg::err_t         row_err_reg,   row_err_next;
    line_rast_pkg::coord_t       col_delta_reg, col_delta_next;
    line_rast_pkg::coord_t       row_delta_reg, row_delta_next;
    line_rast_pkg::dir_t         col_dir_reg,   col_dir_next;
    line_rast_pkg::dir_t         row_dir_reg,   row_dir_next;
    line_rast_pkg::coord_t       major_reg,     major_next;
    line_rast_pkg::count_t       left_reg,      left_next;
    line_rast_pkg::color_t       word_reg,      word_next;

    // output register
    logic                                  out_valid_reg, out_valid_next;
    line_rast_pkg::coord_t                 pixel_x_reg,   pixel_x_next;
    logic [line_rast_pkg::ROW_W-1:0]       pixel_y_reg,   pixel_y_next;
    logic [line_rast_pkg::ADDR_W-1:0]      pixel_addr_reg, pixel_addr_next;
    line_rast_pkg::color_t                 pixel_word_reg, pixel_word_next;
    logic                                  last_reg,      last_next;

    logic                        accept;
    logic                        out_load;
    logic                        is_last;
    line_rast_pkg::coord_t       col_clamp;
    line_rast_pkg::coord_t       row_clamp;
    logic [PROD_W-1:0]           addr_full;
    line_rast_pkg::err_t         col_sum;
    line_rast_pkg::err_t         row_sum;
    line_rast_pkg::coord_t       dx;
    line_rast_pkg::coord_t       dy;

    // output register empty or draining: room for the next transaction
    assign req.ready = !out_valid_reg || pix.ready;
    assign accept    = req.valid && req.ready;

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = pixel_x_reg;
    assign pix.pixel_y    = pixel_y_reg;
    assign pix.pixel_addr = pixel_addr_reg;
    assign pix.pixel_word = pixel_word_reg;
    assign pix.last       = last_reg;

    // pixel of the current point
    assign col_clamp = (cur_col_reg > COL_MAX) ? COL_MAX : cur_col_reg;
    assign row_clamp = (cur_row_reg > ROW_MAX) ? ROW_MAX : cur_row_reg;
    assign addr_full = PROD_W'(row_clamp) * ROW_PITCH + PROD_W'(col_clamp);
    assign is_last   = (left_reg <= line_rast_pkg::COUNT_W'(1));

    // error accumulation, wraps at the accumulator width
    assign col_sum = col_err_reg + line_rast_pkg::ERR_W'(col_delta_reg);
    assign row_sum = row_err_reg + line_rast_pkg::ERR_W'(row_delta_reg);

    // endpoint deltas for a start
    assign dx = (req.x_end > req.x_start) ? (req.x_end - req.x_start)
                                          : (req.x_start - req.x_end);
    assign dy = (req.y_end > req.y_start) ? (req.y_end - req.y_start)
                                          : (req.y_start - req.y_end);

    always_comb
    begin
        active_next    = active_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        col_err_next   = col_err_reg;
        row_err_next   = row_err_reg;
        col_delta_next = col_delta_reg;
        row_delta_next = row_delta_reg;
        col_dir_next   = col_dir_reg;
        row_dir_next   = row_dir_reg;
        major_next     = major_reg;
        left_next      = left_reg;
        word_next      = word_reg;
        out_load       = 1'b0;

        if (accept && req.req_type == line_rast_pkg::REQ_START)
        begin
            // new line replaces whatever was in progress
            col_delta_next = dx;
            row_delta_next = dy;
            if (req.x_end > req.x_start)
                col_dir_next = line_rast_pkg::DIR_POS;
            else if (req.x_end < req.x_start)
                col_dir_next = line_rast_pkg::DIR_NEG;
            else
                col_dir_next = line_rast_pkg::DIR_NONE;
            if (req.y_end > req.y_start)
                row_dir_next = line_rast_pkg::DIR_POS;
            else if (req.y_end < req.y_start)
                row_dir_next = line_rast_pkg::DIR_NEG;
            else
                row_dir_next = line_rast_pkg::DIR_NONE;
            major_next   = (dx > dy) ? dx : dy;
            cur_col_next = req.x_start;
            cur_row_next = req.y_start;
            col_err_next = '0;
            row_err_next = '0;
            left_next    = line_rast_pkg::COUNT_W'(major_next)
                         + line_rast_pkg::COUNT_W'(1);
            // panel wants the color bytes swapped
            word_next    = {req.color[7:0], req.color[15:8]};
            active_next  = 1'b1;
        end
        else if (accept && active_reg)
        begin
            out_load = 1'b1;

            col_err_next = col_sum;
            if (col_sum > line_rast_pkg::ERR_W'(major_reg))
            begin
                col_err_next = col_sum - line_rast_pkg::ERR_W'(major_reg);
                case (col_dir_reg)
                    line_rast_pkg::DIR_POS: cur_col_next = cur_col_reg + 8'd1;
                    line_rast_pkg::DIR_NEG: cur_col_next = cur_col_reg - 8'd1;
                    default:                cur_col_next = cur_col_reg;
                endcase
            end

            row_err_next = row_sum;
            if (row_sum > line_rast_pkg::ERR_W'(major_reg))
            begin
                row_err_next = row_sum - line_rast_pkg::ERR_W'(major_reg);
                case (row_dir_reg)
                    line_rast_pkg::DIR_POS: cur_row_next = cur_row_reg + 8'd1;
                    line_rast_pkg::DIR_NEG: cur_row_next = cur_row_reg - 8'd1;
                    default:                cur_row_next = cur_row_reg;
                endcase
            end

            if (is_last)
            begin
                left_next   = '0;
                active_next = 1'b0;
            end
            else
            begin
                left_next = left_reg - line_rast_pkg::COUNT_W'(1);
            end
        end
        // a step with no line in progress leaves everything as is
    end

    // output register: load on a productive step, else clear when taken
    always_comb
    begin
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        pixel_addr_next = pixel_addr_reg;
        pixel_word_next = pixel_word_reg;
        last_next       = last_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            pixel_x_next    = col_clamp;
            pixel_y_next    = row_clamp[line_rast_pkg::ROW_W-1:0];
            pixel_addr_next = addr_full[line_rast_pkg::ADDR_W-1:0];
            pixel_word_next = word_reg;
            last_next       = is_last;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_col_reg    <= cur_col_next;
        cur_row_reg    <= cur_row_next;
        col_err_reg    <= col_err_next;
        row_err_reg    <= row_err_next;
        col_delta_reg  <= col_delta_next;
        row_delta_reg  <= row_delta_next;
        col_dir_reg    <= col_dir_next;
        row_dir_reg    <= row_dir_next;
        major_reg      <= major_next;
        left_reg       <= left_next;
        word_reg       <= word_next;
        pixel_x_reg    <= pixel_x_next;
        pixel_y_reg    <= pixel_y_next;
        pixel_addr_reg <= pixel_addr_next;
        pixel_word_reg <= pixel_word_next;
        last_reg       <= last_next;
    end

endmodule
